/* rtl/core/fir_lp_pkg.sv */
// Package for the 100-tap low-pass FIR filter: payload types, widths and
// the fixed Q1.15 coefficient table with its lookup function.
// No dependencies; used by fir_lowpass_100_tap.
package fir_lp_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int COEF_COUNT   = 100;
  localparam int COEF_AW      = $clog2(COEF_COUNT);
  // Tap index width covering the largest supported tap count (256)
  localparam int COEF_IDX_W   = 8;
  localparam int TAPS_DEFAULT = 100;
  // Exact sum: 256 products of 16x16 bits fit with ample headroom
  localparam int ACC_W        = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in_block;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } result_t;

  // Hamming-window low-pass coefficients, Q1.15
  localparam logic signed [COEF_W-1:0] COEF_Q15 [COEF_COUNT] = '{
      16'sd10,    16'sd3,     16'sd0,    -16'sd7,   -16'sd10,
     -16'sd16,   -16'sd23,   -16'sd29,   -16'sd33,   -16'sd36,
     -16'sd39,   -16'sd36,   -16'sd29,   -16'sd16,    16'sd0,
      16'sd20,    16'sd46,    16'sd72,    16'sd98,    16'sd121,
      16'sd138,   16'sd147,   16'sd147,   16'sd131,   16'sd102,
      16'sd59,    16'sd0,    -16'sd69,   -16'sd147,  -16'sd229,
     -16'sd308,  -16'sd377,  -16'sd426,  -16'sd452,  -16'sd446,
     -16'sd400,  -16'sd311,  -16'sd177,   16'sd0,     16'sd220,
      16'sd475,   16'sd763,   16'sd1068,  16'sd1380,  16'sd1684,
      16'sd1973,  16'sd2232,  16'sd2444,  16'sd2602,  16'sd2703,
      16'sd2736,  16'sd2703,  16'sd2602,  16'sd2444,  16'sd2232,
      16'sd1973,  16'sd1684,  16'sd1380,  16'sd1068,  16'sd763,
      16'sd475,   16'sd220,   16'sd0,    -16'sd177,  -16'sd311,
     -16'sd400,  -16'sd446,  -16'sd452,  -16'sd426,  -16'sd377,
     -16'sd308,  -16'sd229,  -16'sd147,  -16'sd69,    16'sd0,
      16'sd59,    16'sd102,   16'sd131,   16'sd147,   16'sd147,
      16'sd138,   16'sd121,   16'sd98,    16'sd72,    16'sd46,
      16'sd20,    16'sd0,    -16'sd16,   -16'sd29,   -16'sd36,
     -16'sd39,   -16'sd36,   -16'sd33,   -16'sd29,   -16'sd23,
     -16'sd16,   -16'sd10,   -16'sd7,     16'sd0,     16'sd3
  };

  // Coefficient of tap k; taps past the table are zero
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (k < COEF_IDX_W'(COEF_COUNT)) begin
      c = COEF_Q15[k[COEF_AW-1:0]];
    end
    return c;
  endfunction

endpackage

/* rtl/core/fir_lowpass_100_tap.sv */
// Top level of the TAPS-tap low-pass FIR filter with one shared
// multiply-accumulate and a circular history memory.
// Depends on fir_lp_pkg for payload types, widths and coefficients.
//
// Usage:
//   Input channel (sample_valid / sample_ready / sample) carries one Q1.15
//   sample and a last-of-block flag per transaction. Output channel
//   (result_valid / result_ready / result) returns one rounded, saturated
//   Q1.15 sample per input, in order, with the flag echoed.
//   From acceptance to the result register, each sample takes one
//   multiply-accumulate per tap, fed by one read a cycle from the history
//   memory's read port; then the pipeline drains and the result is loaded.
//   The input is not ready while a sample is in flight; it is ready again
//   in the cycle after the result is loaded, so the next sample is taken as
//   soon as the previous result sits in the output register, even while
//   the receiver stalls it.
//   If the receiver stalls, a finished sum waits until the output register
//   frees up; the history is updated only when the result is loaded.
//   Reset empties the history (fill count to zero) at once; no clearing
//   pass is needed. A sample flagged last-of-block empties the history the
//   same way after its own result is formed.
module fir_lowpass_100_tap #(
  parameter int TAPS = fir_lp_pkg::TAPS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  fir_lp_pkg::sample_t  sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output fir_lp_pkg::result_t  result
);

  localparam int HL  = TAPS - 1;
  localparam int AW  = (HL > 1) ? $clog2(HL) : 1;
  localparam int KW  = $clog2(TAPS);
  localparam int FW  = $clog2(HL + 1);
  localparam int SW  = fir_lp_pkg::SAMPLE_W;
  localparam int CW  = fir_lp_pkg::COEF_W;
  localparam int PW  = SW + CW;
  localparam int AccW = fir_lp_pkg::ACC_W;
  localparam int YW  = AccW - 15;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [AW-1:0]        ADDR_LAST = AW'(HL - 1);
  localparam logic [KW-1:0]        K_LAST    = KW'(TAPS - 1);
  localparam logic [FW-1:0]        FILL_FULL = FW'(HL);
  localparam logic signed [YW-1:0] Y_MAX     = YW'(32767);
  localparam logic signed [YW-1:0] Y_MIN     = YW'(-32768);

  // History memory, newest entry just below wptr
  logic [SW-1:0] mem [HL];
  logic [SW-1:0] rd_data;

  logic [1:0]    state;
  logic [KW-1:0] k;
  logic [AW-1:0] raddr;
  logic [AW-1:0] wptr;
  logic [FW-1:0] fill;

  logic signed [SW-1:0] x;
  logic                 x_last;

  // Pipeline: stage 1 (memory read, coefficient), stage 2 (product)
  logic                 v1;
  logic                 first1;
  logic                 ok1;
  logic signed [CW-1:0] coef1;
  logic                 v2;
  logic signed [PW-1:0] prod;
  logic signed [AccW-1:0] acc;

  logic signed [SW-1:0]   operand;
  logic signed [AccW-1:0] rsum;
  logic signed [YW-1:0]   y;
  logic signed [SW-1:0]   y_sat;
  logic                   load_out;
  logic                   issue;

  assign sample_ready = (state == ST_IDLE);
  assign issue        = (state == ST_ISSUE);
  assign load_out     = (state == ST_FIN) && (!result_valid || result_ready);

  // Select tap operand: current sample for tap 0, zero past the fill count
  always_comb begin
    if (first1) begin
      operand = x;
    end else if (ok1) begin
      operand = $signed(rd_data);
    end else begin
      operand = '0;
    end
  end

  // Round to nearest (ties up) and saturate
  always_comb begin
    rsum = acc + AccW'(16384);
    y    = rsum[AccW-1:15];
    if (y > Y_MAX) begin
      y_sat = 16'sh7fff;
    end else if (y < Y_MIN) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y[SW-1:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      wptr  <= '0;
      fill  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            k     <= '0;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          k <= k + KW'(1);
          if (k == K_LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state <= ST_IDLE;
            if (x_last) begin
              fill <= '0;
            end else begin
              wptr <= (wptr == ADDR_LAST) ? '0 : wptr + AW'(1);
              if (fill != FILL_FULL) begin
                fill <= fill + FW'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the incoming sample; walk the read pointer from newest to oldest
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      x      <= sample.sample_in;
      x_last <= sample.last_in_block;
      raddr  <= (wptr == '0) ? ADDR_LAST : wptr - AW'(1);
    end else if (issue && k != '0) begin
      raddr <= (raddr == '0) ? ADDR_LAST : raddr - AW'(1);
    end
  end

  // History memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (issue && k != '0) begin
      rd_data <= mem[raddr];
    end
    if (load_out && !x_last) begin
      mem[wptr] <= x;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // Stage 1 payload: coefficient and entry validity
  always_ff @(posedge clk) begin
    first1 <= (k == '0);
    ok1    <= (k <= KW'(fill));
    coef1  <= fir_lp_pkg::coef_at(fir_lp_pkg::COEF_IDX_W'(k));
  end

  // Stage 2 multiply, stage 3 accumulate
  always_ff @(posedge clk) begin
    prod <= coef1 * operand;
    if (sample_valid && sample_ready) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + AccW'(prod);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.sample_out <= y_sat;
      result.last_out   <= x_last;
    end
  end

endmodule
